// ===== hdl/third_order_tracking_differentiator_assert.svh =====
`ifndef THIRD_ORDER_TRACKING_DIFFERENTIATOR_ASSERT_SVH
`define THIRD_ORDER_TRACKING_DIFFERENTIATOR_ASSERT_SVH

// cons must hold in the same cycle as ante
`define TOTD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define TOTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/totd_pkg.sv =====
`timescale 1ns / 1ps

package totd_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // Field and register widths
  localparam int FIELD_W    = 32;
  localparam int BW_W       = 16;
  localparam int DT_W       = 16;
  localparam int LIM_W      = 31;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [BW_W-1:0]  BW_RESET   = BW_W'(2560);
  localparam logic [DT_W-1:0]  DT_RESET   = DT_W'(66);
  localparam logic [LIM_W-1:0] VLIM_RESET = LIM_W'(655360);
  localparam logic [LIM_W-1:0] ALIM_RESET = LIM_W'(6553600);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_BANDWIDTH      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TIME_STEP      = cfg_idx_t'(1);
  localparam cfg_idx_t REG_VELOCITY_LIMIT = cfg_idx_t'(2);
  localparam cfg_idx_t REG_ACCEL_LIMIT    = cfg_idx_t'(3);

  // Digit-serial multiplier geometry
  localparam int DIGIT_W    = 8;
  localparam int MCAND_W    = 64;
  localparam int COEF_W     = 3 * BW_W;
  localparam int PROD_W     = COEF_W + MCAND_W;
  localparam int NUM_DIGITS = MCAND_W / DIGIT_W;
  localparam int CNT_W      = $clog2(NUM_DIGITS);
  localparam int RR_W       = 2 * BW_W;
  localparam int JSUM_W     = MCAND_W + 2;
  localparam int SHIFT_W    = 2;

  // Fraction bits dropped after the scaled products, and the same shifts in digits
  localparam int ERR_FRAC = 24;
  localparam int VEL_FRAC = 16;
  localparam int ACC_FRAC = 8;
  localparam int DT_FRAC  = 16;
  localparam logic [SHIFT_W-1:0] SH_NONE = SHIFT_W'(0);
  localparam logic [SHIFT_W-1:0] SH_ERR  = SHIFT_W'(ERR_FRAC / DIGIT_W);
  localparam logic [SHIFT_W-1:0] SH_VEL  = SHIFT_W'(VEL_FRAC / DIGIT_W);
  localparam logic [SHIFT_W-1:0] SH_ACC  = SHIFT_W'(ACC_FRAC / DIGIT_W);
  localparam logic [SHIFT_W-1:0] SH_DT   = SHIFT_W'(DT_FRAC / DIGIT_W);

  // Multiply sequence of one item, in order
  typedef enum logic [2:0] {
    OP_RR,
    OP_R3,
    OP_ERR,
    OP_VEL,
    OP_ACC,
    OP_JDT,
    OP_ADT,
    OP_VDT
  } op_t;

  function automatic logic [SHIFT_W-1:0] op_shift(input op_t op);
    logic [SHIFT_W-1:0] sh;
    case (op)
      OP_RR, OP_R3: sh = SH_NONE;
      OP_ERR:       sh = SH_ERR;
      OP_VEL:       sh = SH_VEL;
      OP_ACC:       sh = SH_ACC;
      default:      sh = SH_DT;
    endcase
    return sh;
  endfunction

endpackage

// ===== hdl/third_order_tracking_differentiator.sv =====
// Third-order linear tracking differentiator. Each accepted in_target (signed Q16.16) moves
// the tracked position, velocity and acceleration one Euler step toward it, with all three
// poles at -r, and returns the new states on the out_ channel. Every product goes through one
// shared digit-serial multiplier (48-bit coefficient times one 8-bit digit of the magnitude
// per cycle), used eight times per item: r*r and r^3 for the coefficients, the three jerk
// terms and the three dt products. Each use steps through ST_LOAD, ST_MUL, ST_SCALE, ST_POST;
// after the last use ST_OUT loads the output register when it is free, and a new item is
// accepted only in ST_IDLE. A finished result waits in the output register while the next
// item is accepted. Configuration writes are always accepted and belong only between items;
// position saturates to DATA_WIDTH signed bits and out_position carries its low 32 bits.
`timescale 1ns / 1ps
`include "third_order_tracking_differentiator_assert.svh"

module third_order_tracking_differentiator #(
  parameter int DATA_WIDTH = totd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [totd_pkg::FIELD_W-1:0]    in_target,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [totd_pkg::FIELD_W-1:0]    out_position,
  output logic signed [totd_pkg::FIELD_W-1:0]    out_velocity,
  output logic signed [totd_pkg::FIELD_W-1:0]    out_acceleration,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [totd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [totd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import totd_pkg::*;

  localparam int EW = ((DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W) + 1;
  localparam logic signed [MCAND_W:0] POS_MAX =
    $signed({{(MCAND_W + 2 - DATA_WIDTH){1'b0}}, {(DATA_WIDTH - 1){1'b1}}});
  localparam logic signed [MCAND_W:0] POS_MIN = ~POS_MAX;
  localparam logic signed [JSUM_W-1:0] I64_MAX =
    $signed({{(JSUM_W - MCAND_W + 1){1'b0}}, {(MCAND_W - 1){1'b1}}});
  localparam logic signed [JSUM_W-1:0] I64_MIN = ~I64_MAX;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_SCALE,
    ST_POST,
    ST_OUT
  } st_t;

  st_t                         state_r;
  op_t                         op_r;
  logic [CNT_W-1:0]            dig_cnt_r;
  logic [MCAND_W-1:0]          mcand_r;
  logic [COEF_W-1:0]           coef_r;
  logic [COEF_W-1:0]           pacc_r;
  logic [MCAND_W-1:0]          plow_r;
  logic                        neg_r;
  logic signed [MCAND_W-1:0]   prod_r;

  logic [BW_W-1:0]             bw_r;
  logic [DT_W-1:0]             dt_r;
  logic [LIM_W-1:0]            vlim_r;
  logic [LIM_W-1:0]            alim_r;
  logic [RR_W-1:0]             rr_r;
  logic [COEF_W-1:0]           c1_r;

  logic signed [DATA_WIDTH-1:0] pos_r;
  logic signed [FIELD_W-1:0]   vel_r;
  logic signed [FIELD_W-1:0]   acc_r;
  logic signed [FIELD_W-1:0]   tgt_r;
  logic signed [JSUM_W-1:0]    jsum_r;

  logic                        out_valid_r;
  logic signed [FIELD_W-1:0]   out_position_r;
  logic signed [FIELD_W-1:0]   out_velocity_r;
  logic signed [FIELD_W-1:0]   out_acceleration_r;

  // Operand load
  logic signed [EW-1:0]        err_w;
  logic [RR_W+1:0]             c2_w;
  logic [BW_W+1:0]             c3_w;
  logic [MCAND_W-1:0]          ld_val;
  logic [COEF_W-1:0]           ld_coef;
  logic                        ld_neg;
  logic [MCAND_W-1:0]          ld_mag;

  // Multiply step
  logic [DIGIT_W-1:0]          mdigit;
  logic [COEF_W+DIGIT_W-1:0]   mpart;
  logic [COEF_W+DIGIT_W-1:0]   msum;

  // Scale and saturate
  logic [PROD_W-1:0]           pfull;
  logic [PROD_W-1:0]           pshift;
  logic [SHIFT_W-1:0]          sh_dig;
  logic                        psat;
  logic [MCAND_W-1:0]          pmag;
  logic [MCAND_W-1:0]          scaled_nxt;

  // State updates
  logic signed [JSUM_W-1:0]    jsum_add;
  logic signed [JSUM_W-1:0]    jneg;
  logic signed [JSUM_W-1:0]    jerk_nxt;
  logic signed [MCAND_W:0]     acc_sum;
  logic signed [MCAND_W:0]     vel_sum;
  logic signed [MCAND_W:0]     pos_sum;
  logic signed [FIELD_W-1:0]   acc_nxt;
  logic signed [FIELD_W-1:0]   vel_nxt;
  logic signed [DATA_WIDTH-1:0] pos_nxt;

  logic signed [FIELD_W-1:0]   vlim_s;
  logic signed [FIELD_W-1:0]   alim_s;

  function automatic logic signed [FIELD_W-1:0] clamp_sym(
    input logic signed [MCAND_W:0] x,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [MCAND_W:0] hi;
    logic signed [MCAND_W:0] lo;
    hi = $signed((MCAND_W + 1)'(lim));
    lo = -hi;
    if (x > hi) begin
      return FIELD_W'(hi);
    end else if (x < lo) begin
      return FIELD_W'(lo);
    end else begin
      return FIELD_W'(x);
    end
  endfunction

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_velocity     = out_velocity_r;
  assign out_acceleration = out_acceleration_r;

  assign vlim_s = $signed(FIELD_W'(vlim_r));
  assign alim_s = $signed(FIELD_W'(alim_r));

  // Pick the magnitude and coefficient for the next multiply
  always_comb begin
    err_w   = EW'(pos_r) - EW'(tgt_r);
    c2_w    = ((RR_W + 2)'(rr_r) << 1) + (RR_W + 2)'(rr_r);
    c3_w    = ((BW_W + 2)'(bw_r) << 1) + (BW_W + 2)'(bw_r);
    ld_val  = '0;
    ld_coef = '0;
    case (op_r)
      OP_RR: begin
        ld_val  = MCAND_W'(bw_r);
        ld_coef = COEF_W'(bw_r);
      end
      OP_R3: begin
        ld_val  = MCAND_W'(bw_r);
        ld_coef = COEF_W'(rr_r);
      end
      OP_ERR: begin
        ld_val  = MCAND_W'(err_w);
        ld_coef = c1_r;
      end
      OP_VEL: begin
        ld_val  = MCAND_W'(vel_r);
        ld_coef = COEF_W'(c2_w);
      end
      OP_ACC: begin
        ld_val  = MCAND_W'(acc_r);
        ld_coef = COEF_W'(c3_w);
      end
      OP_JDT: begin
        ld_val  = jsum_r[MCAND_W-1:0];
        ld_coef = COEF_W'(dt_r);
      end
      OP_ADT: begin
        ld_val  = MCAND_W'(acc_r);
        ld_coef = COEF_W'(dt_r);
      end
      OP_VDT: begin
        ld_val  = MCAND_W'(vel_r);
        ld_coef = COEF_W'(dt_r);
      end
      default: begin
        ld_val  = '0;
        ld_coef = '0;
      end
    endcase
    ld_neg = ld_val[MCAND_W-1];
    ld_mag = ld_neg ? (~ld_val + MCAND_W'(1)) : ld_val;
  end

  // One digit per cycle: add coef*digit, retire the low digit into plow
  always_comb begin
    mdigit = mcand_r[DIGIT_W-1:0];
    mpart  = (COEF_W + DIGIT_W)'(coef_r) * (COEF_W + DIGIT_W)'(mdigit);
    msum   = (COEF_W + DIGIT_W)'(pacc_r) + mpart;
  end

  // Drop fraction digits, saturate the magnitude to 63 bits, restore the sign
  always_comb begin
    pfull      = {pacc_r, plow_r};
    sh_dig     = op_shift(op_r);
    pshift     = pfull >> (DIGIT_W * int'(sh_dig));
    psat       = |pshift[PROD_W-1:MCAND_W-1];
    pmag       = psat ? {1'b0, {(MCAND_W - 1){1'b1}}} : {1'b0, pshift[MCAND_W-2:0]};
    scaled_nxt = neg_r ? (~pmag + MCAND_W'(1)) : pmag;
  end

  always_comb begin
    jsum_add = jsum_r + JSUM_W'(prod_r);
    jneg     = -jsum_add;
    if (jneg > I64_MAX) begin
      jerk_nxt = I64_MAX;
    end else if (jneg < I64_MIN) begin
      jerk_nxt = I64_MIN;
    end else begin
      jerk_nxt = jneg;
    end

    acc_sum = (MCAND_W + 1)'(acc_r) + (MCAND_W + 1)'(prod_r);
    vel_sum = (MCAND_W + 1)'(vel_r) + (MCAND_W + 1)'(prod_r);
    pos_sum = (MCAND_W + 1)'(pos_r) + (MCAND_W + 1)'(prod_r);
    acc_nxt = clamp_sym(acc_sum, alim_r);
    vel_nxt = clamp_sym(vel_sum, vlim_r);
    if (pos_sum > POS_MAX) begin
      pos_nxt = DATA_WIDTH'(POS_MAX);
    end else if (pos_sum < POS_MIN) begin
      pos_nxt = DATA_WIDTH'(POS_MIN);
    end else begin
      pos_nxt = DATA_WIDTH'(pos_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_RR;
      dig_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      bw_r        <= BW_RESET;
      dt_r        <= DT_RESET;
      vlim_r      <= VLIM_RESET;
      alim_r      <= ALIM_RESET;
      pos_r       <= '0;
      vel_r       <= '0;
      acc_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_BANDWIDTH:      bw_r   <= cfg_data[BW_W-1:0];
          REG_TIME_STEP:      dt_r   <= cfg_data[DT_W-1:0];
          REG_VELOCITY_LIMIT: vlim_r <= cfg_data[LIM_W-1:0];
          REG_ACCEL_LIMIT:    alim_r <= cfg_data[LIM_W-1:0];
          default: begin
          end
        endcase
      end

      // in ST_OUT the output register is reloaded instead
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            tgt_r   <= in_target;
            op_r    <= OP_RR;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mcand_r   <= ld_mag;
          coef_r    <= ld_coef;
          neg_r     <= ld_neg;
          pacc_r    <= '0;
          dig_cnt_r <= '0;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          pacc_r    <= msum[COEF_W+DIGIT_W-1:DIGIT_W];
          plow_r    <= {msum[DIGIT_W-1:0], plow_r[MCAND_W-1:DIGIT_W]};
          mcand_r   <= mcand_r >> DIGIT_W;
          dig_cnt_r <= dig_cnt_r + CNT_W'(1);
          if (dig_cnt_r == CNT_W'(NUM_DIGITS - 1)) begin
            state_r <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          prod_r  <= $signed(scaled_nxt);
          state_r <= ST_POST;
        end
        ST_POST: begin
          case (op_r)
            OP_RR:   rr_r   <= prod_r[RR_W-1:0];
            OP_R3:   c1_r   <= prod_r[COEF_W-1:0];
            OP_ERR:  jsum_r <= JSUM_W'(prod_r);
            OP_VEL:  jsum_r <= jsum_add;
            OP_ACC:  jsum_r <= jerk_nxt;
            OP_JDT:  acc_r  <= acc_nxt;
            OP_ADT:  vel_r  <= vel_nxt;
            OP_VDT:  pos_r  <= pos_nxt;
            default: begin
            end
          endcase
          if (op_r == OP_VDT) begin
            state_r <= ST_OUT;
          end else begin
            op_r    <= op_t'(op_r + 3'd1);
            state_r <= ST_LOAD;
          end
        end
        ST_OUT: begin
          // hold until the previous result has been taken
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_position_r     <= FIELD_W'(pos_r);
            out_velocity_r     <= vel_r;
            out_acceleration_r <= acc_r;
            state_r            <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `TOTD_ASSERT_SAME(a_vel_clamped, clk, rst_n, state_r == ST_OUT, (vel_r <= vlim_s) && (vel_r >= -vlim_s), "velocity outside its clamp")
  `TOTD_ASSERT_SAME(a_acc_clamped, clk, rst_n, state_r == ST_OUT, (acc_r <= alim_s) && (acc_r >= -alim_s), "acceleration outside its clamp")
  `TOTD_ASSERT_SAME(a_digits_spent, clk, rst_n, state_r == ST_SCALE, mcand_r == '0, "multiplicand digits left at scale")
  `TOTD_ASSERT_NEXT(a_out_waits, clk, rst_n, (state_r == ST_OUT) && out_valid_r && !out_ready, state_r == ST_OUT, "result loaded over an untaken item")

endmodule

// ===== tb/sv/tracking_check.sv =====
`timescale 1ns / 1ps

module tracking_check #(
  parameter int DATA_WIDTH = totd_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [totd_pkg::FIELD_W-1:0] in_target,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [totd_pkg::FIELD_W-1:0] out_position,
  input  logic signed [totd_pkg::FIELD_W-1:0] out_velocity,
  input  logic signed [totd_pkg::FIELD_W-1:0] out_acceleration,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [totd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [totd_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import totd_pkg::*;

  localparam longint POS_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam longint COEF_THREE = 3;
  localparam logic [127:0] PROD_SAT = 128'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] velocity;
    logic [FIELD_W-1:0] acceleration;
  } track_state_t;

  logic [BW_W-1:0]  bw_r;
  logic [DT_W-1:0]  dt_r;
  logic [LIM_W-1:0] vlim_r;
  logic [LIM_W-1:0] alim_r;

  longint pos_s;
  longint vel_s;
  longint acc_s;

  track_state_t expected_states[$];
  track_state_t want;

  // signed times unsigned, shifted down, magnitude truncated, saturated to 64 bits
  function automatic longint scale_mul(input longint a, input logic [63:0] b,
                                       input int unsigned s);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [127:0] q;
    mag = (a < 0) ? 64'(-a) : 64'(a);
    prod = {64'd0, mag} * {64'd0, b};
    q = prod >> s;
    if (q > PROD_SAT) q = PROD_SAT;
    return (a < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clip(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic track_state_t advance(input logic signed [FIELD_W-1:0] target);
    logic [63:0]  r;
    logic [63:0]  c1;
    logic [63:0]  c2;
    logic [63:0]  c3;
    logic [63:0]  dt;
    longint       err;
    longint       jerk;
    longint       p;
    track_state_t res;
    r = 64'(bw_r);
    dt = 64'(dt_r);
    c1 = r * r * r;
    c2 = 64'(COEF_THREE) * r * r;
    c3 = 64'(COEF_THREE) * r;
    err = pos_s - longint'(target);
    jerk = -(scale_mul(err, c1, ERR_FRAC) + scale_mul(vel_s, c2, VEL_FRAC)
             + scale_mul(acc_s, c3, ACC_FRAC));
    acc_s = clip(acc_s + scale_mul(jerk, dt, DT_FRAC), longint'(alim_r));
    vel_s = clip(vel_s + scale_mul(acc_s, dt, DT_FRAC), longint'(vlim_r));
    p = pos_s + scale_mul(vel_s, dt, DT_FRAC);
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    pos_s = p;
    res.position = pos_s[FIELD_W-1:0];
    res.velocity = vel_s[FIELD_W-1:0];
    res.acceleration = acc_s[FIELD_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bw_r = BW_RESET;
      dt_r = DT_RESET;
      vlim_r = VLIM_RESET;
      alim_r = ALIM_RESET;
      pos_s = 0;
      vel_s = 0;
      acc_s = 0;
      expected_states.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          $error("result item with no item pending");
          fail_count++;
        end else begin
          want = expected_states.pop_front();
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", $signed(want.position),
                   $signed(out_position));
            fail_count++;
          end
          if (out_velocity !== want.velocity) begin
            $error("velocity: expected %0d, got %0d", $signed(want.velocity),
                   $signed(out_velocity));
            fail_count++;
          end
          if (out_acceleration !== want.acceleration) begin
            $error("acceleration: expected %0d, got %0d", $signed(want.acceleration),
                   $signed(out_acceleration));
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BANDWIDTH:      bw_r = cfg_data[BW_W-1:0];
          REG_TIME_STEP:      dt_r = cfg_data[DT_W-1:0];
          REG_VELOCITY_LIMIT: vlim_r = cfg_data[LIM_W-1:0];
          REG_ACCEL_LIMIT:    alim_r = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_states.push_back(advance(in_target));
    end
    pending = expected_states.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import totd_pkg::*;

  localparam int DATA_WIDTH = DATA_WIDTH_DEF;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam cfg_idx_t REG_FIRST_UNUSED = cfg_idx_t'(REG_ACCEL_LIMIT + 1);
  localparam logic [31:0] TGT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] TGT_MIN = 32'h8000_0000;
  localparam logic [31:0] LIM_MAX = 32'h7FFF_FFFF;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [FIELD_W-1:0]   in_target = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [FIELD_W-1:0]   out_position;
  logic signed [FIELD_W-1:0]   out_velocity;
  logic signed [FIELD_W-1:0]   out_acceleration;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int hold_asked = 0;
  int hold_served = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  third_order_tracking_differentiator #(.DATA_WIDTH(DATA_WIDTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_target(in_target),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_position(out_position), .out_velocity(out_velocity),
    .out_acceleration(out_acceleration),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tracking_check #(.DATA_WIDTH(DATA_WIDTH)) check_u (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_target(in_target),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_position(out_position), .out_velocity(out_velocity),
    .out_acceleration(out_acceleration),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_target(input logic [31:0] t);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid and let every pending result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_all(input logic [31:0] bw, input logic [31:0] dt,
                           input logic [31:0] vlim, input logic [31:0] alim);
    write_reg(REG_BANDWIDTH, bw);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_VELOCITY_LIMIT, vlim);
    write_reg(REG_ACCEL_LIMIT, alim);
  endtask

  initial begin
    int ph;
    int k;
    int hold_left;
    logic [31:0] cur_tgt;
    hold_left = 0;
    cur_tgt = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: field extremes
    push_target(32'h0);
    push_target(TGT_MAX);
    push_target(TGT_MIN);
    push_target(32'hFFFF_FFFF);
    push_target(32'h0000_0001);
    push_target(32'h0001_0000);
    push_target(32'h0001_0000);

    // everything at its top, upper data bits set; drive position into saturation
    wait_idle();
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_target(TGT_MAX);
    push_target(TGT_MAX);
    push_target(TGT_MIN);
    push_target(TGT_MIN);
    push_target(TGT_MAX);

    // zero bandwidth
    wait_idle();
    write_reg(REG_BANDWIDTH, 32'h0);
    push_target(TGT_MIN);
    push_target(32'h0);

    // zero clamp magnitudes
    wait_idle();
    write_all(32'(BW_RESET), 32'h0000_8000, 32'h0, 32'h0);
    push_target(TGT_MAX);
    push_target(32'h0010_0000);

    // zero time step holds the states
    wait_idle();
    write_all(32'h0000_0100, 32'h0, LIM_MAX, LIM_MAX);
    push_target(TGT_MAX);
    push_target(TGT_MIN);

    // unknown index must not touch any register
    wait_idle();
    write_reg(REG_FIRST_UNUSED, 32'hFFFF_FFFF);
    write_reg(cfg_idx_t'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)), $urandom);
    push_target(32'h0003_0000);
    push_target(32'hFFFD_0000);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: write_all(32'(BW_RESET), 32'(DT_RESET), 32'(VLIM_RESET), 32'(ALIM_RESET));
        1: write_all($urandom, $urandom, $urandom, $urandom);
        2: write_all(32'h0000_FFFF, 32'h0000_FFFF, LIM_MAX, LIM_MAX);
        3: write_all($urandom_range(0, 512), $urandom_range(1, 8),
                     $urandom_range(0, 1000), $urandom_range(0, 1000));
        4: write_all($urandom_range(0, 65535), $urandom_range(1, 65535),
                     $urandom_range(0, LIM_MAX), $urandom_range(0, LIM_MAX));
        default: write_all(32'(BW_RESET), $urandom_range(1, 4096),
                           32'(VLIM_RESET), 32'(ALIM_RESET));
      endcase
      if ($urandom_range(0, 1) == 0)
        write_reg(cfg_idx_t'($urandom_range(REG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
                  $urandom);
      gaps_on = (ph != NUM_PHASES - 1);
      stalls_on = (ph != NUM_PHASES - 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 40) hold_asked++;
        if (ph < NUM_PHASES - 1 && k % 50 == 0) begin
          gaps_on = ($urandom_range(0, 3) != 0);
          stalls_on = ($urandom_range(0, 3) != 0);
        end
        // hold a target for a stretch so the tracker settles on it
        if (hold_left == 0) begin
          case ($urandom_range(0, 9))
            0:       cur_tgt = TGT_MAX;
            1:       cur_tgt = TGT_MIN;
            2, 3:    cur_tgt = $urandom;
            default: cur_tgt = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
          endcase
          hold_left = $urandom_range(1, 40);
        end
        if ($urandom_range(0, 15) == 0) begin
          push_target($urandom);
        end else begin
          push_target(cur_tgt);
          hold_left--;
        end
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
